// ===== hw/rtl/ishd_pkg.sv =====
`default_nettype none
package ishd_pkg;
  localparam int unsigned MaxEntitiesDef = 1024;
  localparam int unsigned DistFracBitsDef = 8;
  localparam int unsigned IdW = 10;
  localparam int unsigned DistW = 24;
  localparam int unsigned DwellW = 16;
  localparam int unsigned CountW = 11;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    MODE_FORCE = 2'd0,
    MODE_CAND  = 2'd1,
    MODE_END   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  localparam logic [CfgIdxW-1:0] REG_RADIUS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LEAVE  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DWELL  = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IdW-1:0]   entity_id;
    logic [DistW-1:0] distance;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]    entity_id_res;
    logic              is_member;
    logic [DwellW-1:0] dwell_left;
    logic [CountW-1:0] member_count;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    mode_t            mode;
    logic             valid_id;
    logic [IdW-1:0]   entity_id;
    logic             in_radius;
    logic             in_band;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_EXEC,
    BK_SWEEP_RD,
    BK_SWEEP_WR,
    BK_OUT,
    BK_CLEAR
  } bk_state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ishd_ram.sv =====
`default_nettype none
module ishd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ishd_front.sv =====
`default_nettype none
module ishd_front import ishd_pkg::*; #(
  parameter int unsigned MaxEntities = MaxEntitiesDef
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  in_item_t         in_item,
  input  wire [DistW-1:0]  radius,
  input  wire [11:0]       leave_mult,
  output logic             cmd_valid,
  input  wire              cmd_take,
  output cmd_t             cmd
);
  localparam int unsigned ProdW = DistW + 12;
  localparam int unsigned LhsW = DistW + 8;

  // Two-entry queue toward the back part
  cmd_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] cnt;
  cmd_t c_new;
  logic [ProdW-1:0] rhs;
  logic [LhsW-1:0] lhs;

  always_comb begin
    rhs = ProdW'(radius) * ProdW'(leave_mult);
    lhs = {in_item.distance, 8'd0};
    c_new.mode = mode_t'(in_item.mode);
    c_new.entity_id = in_item.entity_id;
    c_new.valid_id = 32'(in_item.entity_id) < MaxEntities;
    c_new.in_radius = in_item.distance <= radius;
    // Leave band: distance*256 against radius*mult (Q4.8 factor), exact
    c_new.in_band = ProdW'(lhs) <= rhs;
  end

  assign full = cnt == 2'd2;
  assign cmd_valid = cnt != 2'd0;
  assign cmd = q[rd_ptr];

  // Advance pointers on transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        q[wr_ptr] <= c_new;
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take && cmd_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((cmd_take && cmd_valid) ? 1 : 0);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overfill");
  a_full_valid: assert property (@(posedge clk) disable iff (rst) full |-> cmd_valid)
    else $error("full while empty");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(cmd_take && cmd_valid)) |=> cnt == $past(cnt) + 2'd1)
    else $error("transfer lost");
endmodule
`default_nettype wire

// ===== hw/rtl/ishd_back.sv =====
`default_nettype none
module ishd_back import ishd_pkg::*; #(
  parameter int unsigned MaxEntities = MaxEntitiesDef
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_valid,
  output logic              cmd_take,
  input  cmd_t              cmd,
  input  wire               radius_nz,
  input  wire [DwellW-1:0]  min_dwell,
  output logic              empty,
  input  wire               pop,
  output out_item_t         out_item
);
  localparam int unsigned AW = $clog2(MaxEntities);
  // Entry: cur, next, seen, forced, dwell
  localparam int unsigned EW = 4 + DwellW;

  bk_state_t state, state_next;
  cmd_t cur_cmd;
  logic [AW-1:0] sw_addr;
  logic [CountW-1:0] count;
  logic [CountW-1:0] sw_n;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic e_cur, e_nxt, e_seen, e_frc;
  logic [DwellW-1:0] e_dw, dec;
  logic n_cur, n_nxt, n_seen, n_frc;
  logic [DwellW-1:0] n_dw;
  out_item_t res, res_next;
  out_item_t out_q;
  logic full_out;
  logic out_load;

  ishd_ram #(.Width(EW), .Depth(MaxEntities)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign {e_cur, e_nxt, e_seen, e_frc, e_dw} = rdata;
  assign dec = (e_dw != '0) ? e_dw - 1'b1 : e_dw;
  assign empty = !full_out;
  assign out_item = out_q;
  assign out_load = (state == BK_OUT) && (!full_out || pop);

  // Entry update for the current item, or for the swept entry during the sweep
  always_comb begin
    n_cur = e_cur;
    n_nxt = e_nxt;
    n_seen = e_seen;
    n_frc = e_frc;
    n_dw = e_dw;
    if (state == BK_SWEEP_WR) begin
      if (radius_nz && e_cur && !e_nxt && !e_seen && e_dw != '0) begin
        n_nxt = 1'b1;
        n_dw = e_dw - 1'b1;
      end
      if (!n_nxt) n_dw = '0;
      n_cur = n_nxt;
      n_nxt = 1'b0;
      n_seen = 1'b0;
      n_frc = 1'b0;
    end else begin
      case (cur_cmd.mode)
        MODE_FORCE: begin
          n_nxt = 1'b1;
          n_frc = 1'b1;
          n_dw = min_dwell;
        end
        MODE_CAND: begin
          if (radius_nz) begin
            n_seen = 1'b1;
            if (!e_nxt) begin
              if (cur_cmd.in_radius) begin
                n_nxt = 1'b1;
                n_dw = e_cur ? dec : min_dwell;
              end else if (e_cur && cur_cmd.in_band) begin
                n_nxt = 1'b1;
                n_dw = dec;
              end else if (e_cur && e_dw != '0) begin
                n_nxt = 1'b1;
                n_dw = dec;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer: clear, read, execute, sweep, present result
  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    we = 1'b0;
    waddr = cur_cmd.entity_id[AW-1:0];
    raddr = cur_cmd.entity_id[AW-1:0];
    wdata = {n_cur, n_nxt, n_seen, n_frc, n_dw};
    res_next = res;
    case (state)
      BK_CLEAR: begin
        we = 1'b1;
        waddr = sw_addr;
        wdata = '0;
        if (32'(sw_addr) == MaxEntities - 1) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        if (cur_cmd.mode == MODE_END) begin
          raddr = '0;
          state_next = BK_SWEEP_WR;
        end else begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        we = cur_cmd.valid_id && cur_cmd.mode != MODE_QUERY;
        res_next.entity_id_res = cur_cmd.entity_id;
        res_next.is_member = cur_cmd.valid_id &&
                             ((cur_cmd.mode == MODE_QUERY) ? e_cur : n_nxt);
        res_next.dwell_left = cur_cmd.valid_id ? n_dw : '0;
        res_next.member_count = count;
        state_next = BK_OUT;
      end
      BK_SWEEP_RD: begin
        raddr = sw_addr;
        state_next = BK_SWEEP_WR;
      end
      BK_SWEEP_WR: begin
        we = 1'b1;
        waddr = sw_addr;
        res_next.entity_id_res = cur_cmd.entity_id;
        res_next.is_member = 1'b0;
        res_next.dwell_left = '0;
        if (32'(sw_addr) == MaxEntities - 1) begin
          res_next.member_count = (n_cur && sw_n != {CountW{1'b1}}) ? sw_n + 1'b1 : sw_n;
          state_next = BK_OUT;
        end else begin
          state_next = BK_SWEEP_RD;
        end
      end
      // Hold the result until the output register is free
      BK_OUT: begin
        if (!full_out || pop) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      full_out <= 1'b0;
      count <= '0;
      sw_addr <= '0;
      sw_n <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        full_out <= 1'b1;
        count <= res.member_count;
      end else if (pop && full_out) begin
        full_out <= 1'b0;
      end
      if (state == BK_READ) begin
        sw_addr <= '0;
        sw_n <= '0;
      end else if (state == BK_SWEEP_WR) begin
        sw_addr <= sw_addr + 1'b1;
        if (n_cur && sw_n != {CountW{1'b1}}) sw_n <= sw_n + 1'b1;
      end else if (state == BK_CLEAR) begin
        sw_addr <= sw_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur_cmd <= cmd;
    res <= res_next;
    if (out_load) out_q <= res;
  end

  a_take_valid: assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("take from empty queue");
  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    !(we && state == BK_IDLE)) else $error("write while idle");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (full_out && !pop) |=> (full_out && $stable(out_q)))
    else $error("result dropped");
endmodule
`default_nettype wire

// ===== hw/rtl/interest_set_hysteresis_dwell_top.sv =====
// An accepted forced, candidate or query item has its entry read, updated and written back,
// then its result registered and handed to the output register. The end-of-snapshot sweep
// reads, then writes each entry. The back part finishes one item (read, update and write of one
// entry, output handoff) before taking the next; a result not yet popped holds the back part,
// and full rises once two items wait. Reset: synchronous rst loads register defaults and empties
// both queues, then a clearing pass zeroes every table entry before the first item is taken.
`default_nettype none
module interest_set_hysteresis_dwell_top import ishd_pkg::*; #(
  parameter int unsigned MaxEntities = MaxEntitiesDef
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  output logic                full,
  input  in_item_t            in_item,
  output logic                empty,
  input  wire                 pop,
  output out_item_t           out_item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [CfgIdxW-1:0]   cfg_index,
  input  wire [31:0]          cfg_data
);
  logic [DistW-1:0] radius;
  logic [11:0] leave_mult;
  logic [DwellW-1:0] min_dwell;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
      leave_mult <= 12'd256;
      min_dwell <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS: radius <= cfg_data[DistW-1:0];
        REG_LEAVE: leave_mult <= cfg_data[11:0];
        REG_DWELL: min_dwell <= cfg_data[DwellW-1:0];
        default: ;
      endcase
    end
  end

  ishd_front #(.MaxEntities(MaxEntities)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .radius(radius), .leave_mult(leave_mult),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  ishd_back #(.MaxEntities(MaxEntities)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .radius_nz(radius != '0), .min_dwell(min_dwell),
    .empty(empty), .pop(pop), .out_item(out_item)
  );
endmodule
`default_nettype wire
